### src/tjrq_pkg.sv
package tjrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);
    localparam int JOB_W       = 16;
    localparam int DUE_W       = 32;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [2:0] KIND_INSERTED = 3'd0;
    localparam logic [2:0] KIND_FULL     = 3'd1;
    localparam logic [2:0] KIND_REMOVED  = 3'd2;
    localparam logic [2:0] KIND_EMPTY    = 3'd3;
    localparam logic [2:0] KIND_RELEASED = 3'd4;
    localparam logic [2:0] KIND_NONE_DUE = 3'd5;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic             valid;
        logic [JOB_W-1:0] job;
        logic [DUE_W-1:0] due;
    } t_slot;

    typedef struct packed {
        t_cell_op         op;
        logic [JOB_W-1:0] job;
        logic [DUE_W-1:0] due;
    } t_cell_ctl;

endpackage

### src/timed_job_release_queue.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------
// in word  | i_valid, o_stall   | i_action, i_job_id, i_start_delay
// out word | o_valid, i_stall   | o_kind, o_job_id_out, o_due_time, o_last
//
// An in word waits in the command register; o_stall is high while it waits,
// so a new in word is taken only once the held one has left that register.
// Insert and remove shift the cell chain at the edge that frees the command register.
// A tick first advances time, then releases due jobs one per out word (at most
// MAX_RESULTS), or gives a single nothing-due word.
// Reset is synchronous and active low; it empties the chain and zeroes time.
// A stalled out word holds all work; one more in word can wait, then o_stall holds.
module timed_job_release_queue #(
    parameter int QUEUE_DEPTH = tjrq_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_job_id,
    input  logic [15:0] i_start_delay,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_job_id_out,
    output logic [31:0] o_due_time,
    output logic        o_last
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TICK = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic                         r_cmd_valid, n_cmd_valid;
    logic [1:0]                   r_cmd_action;
    logic [15:0]                  r_cmd_job;
    logic [15:0]                  r_cmd_delay;
    logic [tjrq_pkg::DUE_W-1:0]   r_now, n_now;
    logic [tjrq_pkg::CNT_W-1:0]   r_count, n_count;
    logic                         r_out_valid, n_out_valid;
    logic [2:0]                   r_out_kind, n_out_kind;
    logic [15:0]                  r_out_job, n_out_job;
    logic [31:0]                  r_out_due, n_out_due;
    logic                         r_out_last, n_out_last;

    tjrq_pkg::t_cell_ctl          w_ctl;
    tjrq_pkg::t_slot              w_slot  [QUEUE_DEPTH];
    logic                         w_stays [QUEUE_DEPTH];

    logic                         w_in_take;
    logic                         w_out_free;
    logic [32:0]                  w_sum;
    logic [31:0]                  w_due;
    logic                         w_full;
    logic                         w_release;
    logic                         w_rel_last;

    localparam tjrq_pkg::t_slot EMPTY_SLOT = '{valid: 1'b0, job: '0, due: '0};

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            tjrq_pkg::t_slot w_prev;
            tjrq_pkg::t_slot w_next;
            logic            w_prev_stays;
            if (g == 0) begin : g_head
                assign w_prev       = EMPTY_SLOT;
                assign w_prev_stays = 1'b1;
            end else begin : g_body
                assign w_prev       = w_slot[g-1];
                assign w_prev_stays = w_stays[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next = EMPTY_SLOT;
            end else begin : g_mid
                assign w_next = w_slot[g+1];
            end
            tjrq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev       (w_prev),
                .i_prev_stays (w_prev_stays),
                .i_next       (w_next),
                .o_slot       (w_slot[g]),
                .o_stays      (w_stays[g])
            );
        end
    endgenerate

    assign o_stall    = r_cmd_valid;
    assign w_in_take  = i_valid && !r_cmd_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_sum  = {1'b0, r_now} + {17'b0, r_cmd_delay};
    assign w_due  = w_sum[32] ? '1 : w_sum[31:0];
    assign w_full = w_slot[QUEUE_DEPTH-1].valid;

    assign w_release  = w_slot[0].valid && (w_slot[0].due <= r_now);
    assign w_rel_last = (r_count == tjrq_pkg::CNT_W'(tjrq_pkg::MAX_RESULTS - 1))
                        || !w_slot[1].valid || (w_slot[1].due > r_now);

    always_comb begin
        n_state     = r_state;
        n_cmd_valid = r_cmd_valid;
        n_now       = r_now;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_out_kind  = r_out_kind;
        n_out_job   = r_out_job;
        n_out_due   = r_out_due;
        n_out_last  = r_out_last;
        w_ctl       = '{op: tjrq_pkg::CELL_HOLD, job: r_cmd_job, due: w_due};

        if (w_in_take) begin
            n_cmd_valid = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (r_cmd_valid && w_out_free) begin
                    n_cmd_valid = 1'b0;
                    n_out_job   = '0;
                    n_out_due   = '0;
                    n_out_last  = 1'b1;
                    case (r_cmd_action)
                        tjrq_pkg::ACT_INSERT: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_kind = tjrq_pkg::KIND_FULL;
                            end else begin
                                n_out_kind = tjrq_pkg::KIND_INSERTED;
                                w_ctl.op   = tjrq_pkg::CELL_INSERT;
                            end
                        end
                        tjrq_pkg::ACT_REMOVE: begin
                            n_out_valid = 1'b1;
                            if (w_slot[0].valid) begin
                                n_out_kind = tjrq_pkg::KIND_REMOVED;
                                n_out_job  = w_slot[0].job;
                                n_out_due  = w_slot[0].due;
                                w_ctl.op   = tjrq_pkg::CELL_POP;
                            end else begin
                                n_out_kind = tjrq_pkg::KIND_EMPTY;
                            end
                        end
                        tjrq_pkg::ACT_TICK: begin
                            if (r_now != '1) begin
                                n_now = r_now + 32'd1;
                            end
                            n_count = '0;
                            n_state = ST_TICK;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (w_release) begin
                        n_out_kind = tjrq_pkg::KIND_RELEASED;
                        n_out_job  = w_slot[0].job;
                        n_out_due  = w_slot[0].due;
                        n_out_last = w_rel_last;
                        w_ctl.op   = tjrq_pkg::CELL_POP;
                        n_count    = r_count + 1'b1;
                        if (w_rel_last) begin
                            n_count = '0;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_out_kind = tjrq_pkg::KIND_NONE_DUE;
                        n_out_job  = '0;
                        n_out_due  = '0;
                        n_out_last = 1'b1;
                        n_count    = '0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmd_valid <= 1'b0;
            r_now       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd_valid <= n_cmd_valid;
            r_now       <= n_now;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cmd_action <= i_action;
            r_cmd_job    <= i_job_id;
            r_cmd_delay  <= i_start_delay;
        end
        r_out_kind <= n_out_kind;
        r_out_job  <= n_out_job;
        r_out_due  <= n_out_due;
        r_out_last <= n_out_last;
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_job_id_out = r_out_job;
    assign o_due_time   = r_out_due;
    assign o_last       = r_out_last;

`ifndef SYNTHESIS
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot[1].valid |-> (w_slot[0].valid && (w_slot[0].due <= w_slot[1].due)))
        else $error("chain order broken at head");

    a_tick_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK) ##1 (r_state == ST_IDLE) |-> (r_out_valid && r_out_last))
        else $error("release run ended without last word");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_state == ST_TICK))
        else $error("release count live outside tick");

    a_tail_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_slot[QUEUE_DEPTH-1].valid |-> w_slot[QUEUE_DEPTH-2].valid)
        else $error("hole before tail cell");
`endif

endmodule

### src/tjrq_cell.sv
module tjrq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tjrq_pkg::t_cell_ctl i_ctl,
    input  tjrq_pkg::t_slot   i_prev,
    input  logic              i_prev_stays,
    input  tjrq_pkg::t_slot   i_next,
    output tjrq_pkg::t_slot   o_slot,
    output logic              o_stays
);

    logic                       r_valid;
    logic [tjrq_pkg::JOB_W-1:0] r_job;
    logic [tjrq_pkg::DUE_W-1:0] r_due;
    tjrq_pkg::t_slot            n_slot;

    assign o_stays = r_valid && (r_due <= i_ctl.due);
    assign o_slot  = '{valid: r_valid, job: r_job, due: r_due};

    always_comb begin
        n_slot = o_slot;
        unique case (i_ctl.op)
            tjrq_pkg::CELL_INSERT: begin
                if (!o_stays) begin
                    if (i_prev_stays) begin
                        n_slot = '{valid: 1'b1, job: i_ctl.job, due: i_ctl.due};
                    end else begin
                        n_slot = i_prev;
                    end
                end
            end
            tjrq_pkg::CELL_POP: begin
                n_slot = i_next;
            end
            default: begin
                n_slot = o_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_slot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_slot.job;
        r_due <= n_slot.due;
    end

endmodule

### verif/testbench.sv
module testbench;

    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         RANDOM_WORDS   = 205;
    localparam int         QUIET_TAIL     = 30;
    localparam int         RX_HOLD_CYCLES = 80;
    localparam int         SETTLE_CYCLES  = 40;
    localparam int         WATCHDOG_LIMIT = 2000;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_DRAIN,
        OP_HOLD_RX
    } t_word_op;

    typedef struct {
        t_word_op    op;
        logic [1:0]  action;
        logic [15:0] job;
        logic [15:0] delay;
    } t_queued_word;

    typedef struct {
        logic [2:0]  kind;
        logic [15:0] job;
        logic [31:0] due;
        logic        last;
    } t_release_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_action = 2'd0;
    logic [15:0] i_job_id = 16'd0;
    logic [15:0] i_start_delay = 16'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [15:0] o_job_id_out;
    logic [31:0] o_due_time;
    logic        o_last;

    t_queued_word  pending_words[$];
    t_release_word awaited_words[$];
    logic [15:0]   held_job[$];
    logic [31:0]   held_due[$];
    logic [31:0]   model_now = 32'd0;
    int            mismatches = 0;
    int            tx_gap = 0;
    int            rx_left = 0;
    int            hold_requests = 0;
    int            hold_seen = 0;
    int            quiet_cycles = 0;
    logic          tail_quiet = 1'b0;

    timed_job_release_queue u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_job_id     (i_job_id),
        .i_start_delay(i_start_delay),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_job_id_out (o_job_id_out),
        .o_due_time   (o_due_time),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic void await_word(input logic [2:0] kind, input logic [15:0] job,
                                       input logic [31:0] due, input logic last);
        t_release_word w;
        w.kind = kind;
        w.job  = job;
        w.due  = due;
        w.last = last;
        awaited_words.push_back(w);
    endfunction

    function automatic void predict_release_words(input logic [1:0] action,
                                                  input logic [15:0] job,
                                                  input logic [15:0] delay);
        logic [32:0] sum;
        logic [31:0] due;
        logic [15:0] out_job;
        logic [31:0] out_due;
        logic        more;
        int          pos;
        int          n;
        case (action)
            tjrq_pkg::ACT_INSERT: begin
                if (held_due.size() >= tjrq_pkg::QUEUE_DEPTH) begin
                    await_word(tjrq_pkg::KIND_FULL, 16'd0, 32'd0, 1'b1);
                end else begin
                    sum = {1'b0, model_now} + {17'd0, delay};
                    due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    pos = 0;
                    while (pos < held_due.size() && held_due[pos] <= due) pos++;
                    held_due.insert(pos, due);
                    held_job.insert(pos, job);
                    await_word(tjrq_pkg::KIND_INSERTED, 16'd0, 32'd0, 1'b1);
                end
            end
            tjrq_pkg::ACT_REMOVE: begin
                if (held_due.size() == 0) begin
                    await_word(tjrq_pkg::KIND_EMPTY, 16'd0, 32'd0, 1'b1);
                end else begin
                    out_job = held_job.pop_front();
                    out_due = held_due.pop_front();
                    await_word(tjrq_pkg::KIND_REMOVED, out_job, out_due, 1'b1);
                end
            end
            tjrq_pkg::ACT_TICK: begin
                if (model_now != 32'hFFFF_FFFF) model_now++;
                n = 0;
                while (n < tjrq_pkg::MAX_RESULTS && held_due.size() > 0
                       && held_due[0] <= model_now) begin
                    out_job = held_job.pop_front();
                    out_due = held_due.pop_front();
                    more = (n + 1 < tjrq_pkg::MAX_RESULTS) && held_due.size() > 0
                           && held_due[0] <= model_now;
                    await_word(tjrq_pkg::KIND_RELEASED, out_job, out_due, !more);
                    n++;
                end
                if (n == 0) await_word(tjrq_pkg::KIND_NONE_DUE, 16'd0, 32'd0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_word(input logic [1:0] action, input logic [15:0] job,
                                       input logic [15:0] delay);
        t_queued_word w;
        w.op     = OP_SEND;
        w.action = action;
        w.job    = job;
        w.delay  = delay;
        pending_words.push_back(w);
    endfunction

    function automatic void queue_marker(input t_word_op op);
        t_queued_word w;
        w.op     = op;
        w.action = ACT_UNUSED;
        w.job    = 16'd0;
        w.delay  = 16'd0;
        pending_words.push_back(w);
    endfunction

    function automatic logic [15:0] pick_delay();
        if ($urandom_range(15, 0) == 0) return 16'($urandom_range(65535, 0));
        return 16'($urandom_range(6, 0));
    endfunction

    // driver
    always @(posedge i_clk) begin
        logic         took;
        logic         send;
        logic         stuck;
        t_queued_word nxt;
        took  = i_valid && !o_stall;
        send  = 1'b0;
        stuck = 1'b0;
        if (i_rst_n) begin
            if (took) begin
                predict_release_words(i_action, i_job_id, i_start_delay);
            end
            if (took || !i_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (!tail_quiet && $urandom_range(4, 0) == 0) begin
                    tx_gap = $urandom_range(11, 0);
                end else begin
                    while (!send && !stuck && pending_words.size() > 0) begin
                        case (pending_words[0].op)
                            OP_HOLD_RX: begin
                                hold_requests <= hold_requests + 1;
                                void'(pending_words.pop_front());
                            end
                            OP_DRAIN: begin
                                if (awaited_words.size() == 0) begin
                                    void'(pending_words.pop_front());
                                end else begin
                                    stuck = 1'b1;
                                end
                            end
                            default: begin
                                nxt  = pending_words.pop_front();
                                send = 1'b1;
                            end
                        endcase
                    end
                end
                i_valid <= send;
                if (send) begin
                    i_action      <= nxt.action;
                    i_job_id      <= nxt.job;
                    i_start_delay <= nxt.delay;
                end
            end
            tail_quiet <= pending_words.size() < QUIET_TAIL;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            rx_left = RX_HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (rx_left > 0) begin
            rx_left--;
            i_stall <= 1'b1;
        end else if (!tail_quiet && $urandom_range(5, 0) == 0) begin
            rx_left = $urandom_range(11, 0);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_release_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_words.size() == 0) begin
                $error("unexpected out word: kind %0d job %0h due %0h last %0d",
                       o_kind, o_job_id_out, o_due_time, o_last);
                mismatches++;
            end else begin
                want = awaited_words.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    mismatches++;
                end
                if (o_job_id_out !== want.job) begin
                    $error("job_id_out: expected %0h, got %0h", want.job, o_job_id_out);
                    mismatches++;
                end
                if (o_due_time !== want.due) begin
                    $error("due_time: expected %0h, got %0h", want.due, o_due_time);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sent;
        int k;
        int r;
        bit hold_done;
        bit drain_done;
        sent       = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        // empty queue cases, unused code, field extremes
        queue_word(tjrq_pkg::ACT_REMOVE, 16'hFFFF, 16'hFFFF);
        queue_word(tjrq_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF);
        queue_word(ACT_UNUSED, 16'h1234, 16'h0003);
        queue_word(tjrq_pkg::ACT_INSERT, 16'hFFFF, 16'hFFFF);
        queue_word(tjrq_pkg::ACT_REMOVE, 16'd0, 16'd0);
        // fill with tied due times, overflow once, release all on one tick
        for (int i = 0; i < tjrq_pkg::QUEUE_DEPTH; i++) begin
            queue_word(tjrq_pkg::ACT_INSERT, (i == 0) ? 16'd0 : 16'(16'hA000 + i),
                       16'(i % 2));
        end
        queue_word(tjrq_pkg::ACT_INSERT, 16'h5555, 16'd0);
        queue_word(tjrq_pkg::ACT_TICK, 16'd0, 16'd0);

        while (sent < RANDOM_WORDS) begin
            if (!hold_done && sent >= 60) begin
                queue_marker(OP_HOLD_RX);
                hold_done = 1'b1;
            end
            if (!drain_done && sent >= 130) begin
                queue_marker(OP_DRAIN);
                drain_done = 1'b1;
            end
            case ($urandom_range(3, 0))
                0: begin
                    k = $urandom_range(18, 3);
                    for (int i = 0; i < k; i++) begin
                        queue_word(tjrq_pkg::ACT_INSERT, 16'($urandom_range(65535, 0)),
                                   16'($urandom_range(3, 0)));
                    end
                    sent += k;
                    k = $urandom_range(6, 1);
                    for (int i = 0; i < k; i++) begin
                        queue_word(tjrq_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
                    end
                    sent += k;
                end
                1: begin
                    for (int i = 0; i < 10; i++) begin
                        r = $urandom_range(19, 0);
                        if (r < 8) begin
                            queue_word(tjrq_pkg::ACT_INSERT,
                                       16'($urandom_range(65535, 0)), pick_delay());
                            sent++;
                        end else if (r < 14) begin
                            queue_word(tjrq_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
                            sent++;
                        end else if (r < 18) begin
                            queue_word(tjrq_pkg::ACT_REMOVE, 16'($urandom),
                                       16'($urandom));
                            sent++;
                        end else begin
                            queue_word(ACT_UNUSED, 16'($urandom), 16'($urandom));
                        end
                    end
                end
                2: begin
                    k = $urandom_range(6, 1);
                    for (int i = 0; i < k; i++) begin
                        queue_word(tjrq_pkg::ACT_REMOVE, 16'($urandom), 16'($urandom));
                    end
                    sent += k;
                end
                default: begin
                    k = $urandom_range(8, 1);
                    for (int i = 0; i < k; i++) begin
                        queue_word(tjrq_pkg::ACT_TICK, 16'($urandom), 16'($urandom));
                    end
                    sent += k;
                end
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() > 0 || i_valid || awaited_words.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (awaited_words.size() > 0) begin
            $error("%0d expected out words never arrived", awaited_words.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
src/tjrq_pkg.sv
src/tjrq_cell.sv
src/timed_job_release_queue.sv
verif/testbench.sv
